// File: hw/rtl/gcd_lcm_unit_defines.svh
// ----------------------------------------------------------------------------
// gcd_lcm_unit_defines.svh
// Assertion macros shared by the GCD/LCM unit. Each one expects clk and rst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define GL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcd_lcm_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define GL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcd_lcm_unit: next-cycle check failed");

`endif

// File: hw/rtl/gcdlcm_pkg.sv
// ----------------------------------------------------------------------------
// gcdlcm_pkg
// Widths, word types and sequencer states for the GCD/LCM unit.
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int PRODUCT_BITS = 2 * OPERAND_BITS;
    localparam int COUNT_BITS   = $clog2(OPERAND_BITS + 1);

    typedef struct packed {
        logic [OPERAND_BITS-1:0] first_value;
        logic [OPERAND_BITS-1:0] second_value;
    } operand_t;

    typedef struct packed {
        logic [OPERAND_BITS-1:0] gcd_value;
        logic [PRODUCT_BITS-1:0] lcm_value;
        logic                    lcm_defined;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_SCALE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

endpackage

// File: hw/rtl/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two operands.
// ----------------------------------------------------------------------------
// Takes one operand word at a time and returns one result word. The divisor
// is found by a binary (shift and subtract) GCD loop that does one step per
// cycle, then doubled back up once per common factor of two. For two nonzero
// operands the multiple is then formed as (first / gcd) * second by a
// restoring divider and a shift-add multiplier. One word is in work at a
// time; a finished result waits in the output register while the next
// operand word is taken. With both operands zero the multiple reads 0 and
// lcm_defined is low.
module gcd_lcm_unit
    import gcdlcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     operand_valid,
    output logic     operand_stall,
    input  operand_t operand,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

`include "gcd_lcm_unit_defines.svh"

    localparam int W = OPERAND_BITS;

    state_t                  state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    logic [W-1:0]            x_reg, x_next;
    logic [W-1:0]            y_reg, y_next;
    logic [W-1:0]            a_reg, a_next;
    logic [W-1:0]            b_reg, b_next;
    logic [COUNT_BITS-1:0]   k_reg, k_next;
    logic [W-1:0]            gcd_reg, gcd_next;
    logic [W-1:0]            rem_reg, rem_next;
    logic [W-1:0]            quo_reg, quo_next;
    logic [PRODUCT_BITS-1:0] prod_reg, prod_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;

    logic                    in_take;
    logic                    gcd_end;
    logic                    zero_op;
    logic                    out_free;
    logic                    last_cnt;
    logic [W-1:0]            diff_ab;
    logic [W-1:0]            diff_ba;
    logic [W:0]              rem_sh;
    logic [W:0]              rem_sub;
    logic                    rem_ge;
    logic [W:0]              mul_sum;

    // Handshake
    assign in_take       = operand_valid && !operand_stall;
    assign operand_stall = (state_reg != ST_IDLE);
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;
    assign out_free      = !out_valid_reg || !result_stall;

    // Shared datapath terms
    assign gcd_end  = (a_reg == '0) || (b_reg == '0);
    assign zero_op  = (x_reg == '0) || (y_reg == '0);
    assign last_cnt = (cnt_reg == COUNT_BITS'(1));
    assign diff_ab  = a_reg - b_reg;
    assign diff_ba  = b_reg - a_reg;
    assign rem_sh   = {rem_reg, quo_reg[W-1]};
    assign rem_sub  = rem_sh - {1'b0, gcd_reg};
    assign rem_ge   = (rem_sh >= {1'b0, gcd_reg});
    assign mul_sum  = {1'b0, prod_reg[PRODUCT_BITS-1:W]}
                    + (prod_reg[0] ? {1'b0, y_reg} : {(W+1){1'b0}});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (gcd_end)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (k_reg == '0)
                    state_next = zero_op ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (last_cnt)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (last_cnt)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        gcd_next       = gcd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                // Capture operands
                if (in_take)
                begin
                    x_next = operand.first_value;
                    y_next = operand.second_value;
                    a_next = operand.first_value;
                    b_next = operand.second_value;
                    k_next = '0;
                end
            end
            ST_GCD:
            begin
                // One binary GCD step
                if (gcd_end)
                    gcd_next = a_reg | b_reg;
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + COUNT_BITS'(1);
                end
                else if (!a_reg[0])
                    a_next = a_reg >> 1;
                else if (!b_reg[0])
                    b_next = b_reg >> 1;
                else if (a_reg >= b_reg)
                    a_next = diff_ab >> 1;
                else
                    b_next = diff_ba >> 1;
            end
            ST_SCALE:
            begin
                // Restore common factors of two, then arm the divider
                if (k_reg != '0)
                begin
                    gcd_next = gcd_reg << 1;
                    k_next   = k_reg - COUNT_BITS'(1);
                end
                else
                begin
                    rem_next = '0;
                    quo_next = x_reg;
                    cnt_next = COUNT_BITS'(W);
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle
                rem_next = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], rem_ge};
                cnt_next = cnt_reg - COUNT_BITS'(1);
                if (last_cnt)
                begin
                    prod_next = {{W{1'b0}}, quo_reg[W-2:0], rem_ge};
                    cnt_next  = COUNT_BITS'(W);
                end
            end
            ST_MUL:
            begin
                // Shift-add one multiplier bit per cycle
                prod_next = {mul_sum, prod_reg[W-1:1]};
                cnt_next  = cnt_reg - COUNT_BITS'(1);
            end
            ST_DONE:
            begin
                // Hand the result word to the output register
                if (out_free)
                begin
                    out_next.gcd_value   = gcd_reg;
                    out_next.lcm_value   = zero_op ? '0 : prod_reg;
                    out_next.lcm_defined = (x_reg != '0) || (y_reg != '0);
                    out_valid_next       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
        gcd_reg  <= gcd_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        prod_reg <= prod_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    // Checks
    `GL_ASSERT_NOW(a_undef_is_zero, result_valid && !result.lcm_defined,
        result.gcd_value == '0 && result.lcm_value == '0)
    `GL_ASSERT_NOW(a_div_rem_below, state_reg == ST_DIV,
        gcd_reg != '0 && rem_reg < gcd_reg)
    `GL_ASSERT_NEXT(a_mul_to_done, state_reg == ST_MUL && last_cnt,
        state_reg == ST_DONE)

endmodule

// File: tb/gcd_lcm_checker.sv
// ----------------------------------------------------------------------------
// gcd_lcm_checker
// Watches both channels of the GCD/LCM unit. It predicts each result word
// from the accepted operand word and compares the words in order.
// ----------------------------------------------------------------------------
// Every accepted operand word queues one predicted result: the divisor by
// Euclid's remainder loop and the multiple as (first / gcd) * second at full
// width. Each accepted result word is checked field by field against the
// oldest prediction. The top reads the error tally and the number of results
// still owed.
module gcd_lcm_checker
    import gcdlcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     operand_valid,
    input  logic     operand_stall,
    input  operand_t operand,
    input  logic     result_valid,
    input  logic     result_stall,
    input  result_t  result,
    output int       mismatch_count,
    output int       results_owed
);

    // keep the log readable if the unit is badly broken
    localparam int REPORT_LIMIT = 100;

    result_t pending_results[$];
    int      errors_seen = 0;

    // Euclid on the operand pair; multiple only when both operands are nonzero
    function automatic result_t gcd_lcm_of(input operand_t w);
        logic [OPERAND_BITS-1:0] a;
        logic [OPERAND_BITS-1:0] b;
        logic [OPERAND_BITS-1:0] rem;
        logic [PRODUCT_BITS-1:0] multiple;
        result_t                 r;
        a = w.first_value;
        b = w.second_value;
        while (b != '0)
        begin
            rem = a % b;
            a   = b;
            b   = rem;
        end
        multiple = '0;
        if (w.first_value != '0 && w.second_value != '0)
        begin
            multiple = PRODUCT_BITS'(w.first_value / a);
            multiple = multiple * PRODUCT_BITS'(w.second_value);
        end
        r.gcd_value   = a;
        r.lcm_value   = multiple;
        r.lcm_defined = (w.first_value != '0) || (w.second_value != '0);
        return r;
    endfunction

    task automatic report_field(input string field, input logic [PRODUCT_BITS-1:0] want,
                                input logic [PRODUCT_BITS-1:0] got);
        errors_seen++;
        if (errors_seen <= REPORT_LIMIT)
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endtask

    // Queue a prediction per accepted operand word, check each result word
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            pending_results.delete();
        end
        else
        begin
            if (operand_valid && !operand_stall)
                pending_results.push_back(gcd_lcm_of(operand));
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors_seen++;
                    if (errors_seen <= REPORT_LIMIT)
                        $display("%0t: result word expected none got gcd %0d lcm %0d def %0b",
                                 $time, result.gcd_value, result.lcm_value,
                                 result.lcm_defined);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.gcd_value !== want.gcd_value)
                        report_field("gcd_value", PRODUCT_BITS'(want.gcd_value),
                                     PRODUCT_BITS'(result.gcd_value));
                    if (result.lcm_value !== want.lcm_value)
                        report_field("lcm_value", want.lcm_value, result.lcm_value);
                    if (result.lcm_defined !== want.lcm_defined)
                        report_field("lcm_defined", PRODUCT_BITS'(want.lcm_defined),
                                     PRODUCT_BITS'(result.lcm_defined));
                end
            end
        end
        mismatch_count <= errors_seen;
        results_owed   <= pending_results.size();
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the GCD/LCM unit: operand stimulus, result stalls, verdict.
// ----------------------------------------------------------------------------
// A directed set covers zero operands, full-scale values, shared powers of
// two and a worst case for Euclid's loop. Random words follow: full-width
// pairs, pairs with a shared factor, shifted odd values, small values and
// zero operands. The sender works in bursts with random gaps; the receiver
// stalls on its own pattern and now and then holds off long enough to back
// the unit up into its input. The checker beside the unit does the scoring.
module tb_top
    import gcdlcm_pkg::*;
();

    localparam logic [OPERAND_BITS-1:0] OP_MAX = '1;
    localparam int RANDOM_WORDS = 1680;
    localparam int TAIL_CYCLES  = 200;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     operand_valid;
    logic     operand_stall;
    operand_t operand;
    logic     result_valid;
    logic     result_stall;
    result_t  result;
    int       mismatch_count;
    int       results_owed;
    int       burst_left;

    always #1 clk = ~clk;

    gcd_lcm_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    gcd_lcm_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .operand_valid  (operand_valid),
        .operand_stall  (operand_stall),
        .operand        (operand),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    function automatic operand_t pair(input longint unsigned a, input longint unsigned b);
        operand_t w;
        w.first_value  = a[OPERAND_BITS-1:0];
        w.second_value = b[OPERAND_BITS-1:0];
        return w;
    endfunction

    // Pick a random operand word from a mix of shapes
    function automatic operand_t random_pair();
        operand_t          w;
        longint unsigned   factor;
        longint unsigned   span;
        int unsigned       kind;
        kind = $urandom_range(0, 99);
        w = pair($urandom, $urandom);
        if (kind < 35)
        begin
            // full-width pair, long Euclid runs
        end
        else if (kind < 65)
        begin
            // shared factor of random size
            factor = $urandom_range(2, 1 << $urandom_range(1, 20));
            span   = OP_MAX / factor;
            w = pair(factor * $urandom_range(0, span), factor * $urandom_range(1, span));
        end
        else if (kind < 80)
        begin
            // odd values shifted up, so factors of two are common
            w = pair(longint'($urandom | 1) << $urandom_range(0, 30),
                     longint'($urandom | 1) << $urandom_range(0, 30));
        end
        else if (kind < 92)
        begin
            w = pair($urandom_range(0, 255), $urandom_range(0, 255));
        end
        else if (kind < 96)
        begin
            w.first_value = '0;
        end
        else if (kind < 99)
        begin
            w.second_value = '0;
        end
        else
        begin
            w = pair(0, 0);
        end
        return w;
    endfunction

    // Offer one word, hold it until taken, then maybe end the burst
    task automatic send_word(input operand_t w);
        int gap;
        operand       <= w;
        operand_valid <= 1'b1;
        @(posedge clk);
        while (operand_stall)
            @(posedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            operand_valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 6);
            repeat (gap)
                @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Drop valid and wait for every owed result to come back
    task automatic drain_results();
        operand_valid <= 1'b0;
        @(posedge clk);
        wait (results_owed == 0);
        @(posedge clk);
    endtask

    // Sender: reset, directed words, random words, verdict
    initial
    begin
        operand_t directed[$];
        rst_n         <= 1'b0;
        operand_valid <= 1'b0;
        operand       <= '0;
        burst_left = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            pair(0, 0), pair(0, OP_MAX), pair(OP_MAX, 0), pair(0, 1), pair(1, 0),
            pair(1, 1), pair(OP_MAX, OP_MAX), pair(OP_MAX, OP_MAX - 1), pair(OP_MAX, 1),
            pair(1, OP_MAX), pair(2, OP_MAX), pair(1 << 30, 1 << 30),
            pair(1 << 30, 3), pair(3 << 28, 5 << 25), pair(12, 18), pair(96, 0),
            pair(1836311903, 1134903170), pair(1134903170, 1836311903),
            pair(32'h2AAAAAAA, 32'h55555555), pair(1 << 30, (1 << 30) - 1)
        };
        foreach (directed[i])
            send_word(directed[i]);
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
                drain_results();
            send_word(random_pair());
        end
        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Receiver: stall pattern switches to a random mode for a random span
    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       hold_left;
        longint   rx_cycles;
        result_stall <= 1'b0;
        rx_mode   = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        rx_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            // long hold-off so the unit fills and stalls its input
            if (rx_cycles % 50000 == 20000)
                hold_left = 1500;
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 400);
            end
            else
            begin
                mode_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (rx_mode)
                    RX_FREE:  result_stall <= 1'b0;
                    RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                    default:  result_stall <= ((rx_cycles % 8) < 5);
                endcase
            end
        end
    end

    // Give up on a hung run
    initial
    begin
        #4000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
